>>> hdl/sle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg: shared types and constants for the serial line editor
// item kinds, emitter phases, the decoded item struct and character codes
// ----------------------------------------------------------------------------
package sle_pkg;

    // character codes
    localparam logic [7:0] ASCII_ETX   = 8'h03;
    localparam logic [7:0] ASCII_BS    = 8'h08;
    localparam logic [7:0] ASCII_LF    = 8'h0A;
    localparam logic [7:0] ASCII_CR    = 8'h0D;
    localparam logic [7:0] ASCII_ESC   = 8'h1B;
    localparam logic [7:0] ASCII_DEL   = 8'h7F;
    localparam logic [7:0] ASCII_CARET = 8'h5E;
    localparam logic [7:0] ASCII_C     = 8'h43;
    localparam logic [7:0] PRINT_LO    = 8'd32;
    localparam logic [7:0] PRINT_HI    = 8'd126;

    // bytes dropped after an escape
    localparam logic [2:0] ESC_SKIP_COUNT = 3'd4;

    // line event codes
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_LINE   = 2'd1;
    localparam logic [1:0] EV_CANCEL = 2'd2;

    typedef enum logic [1:0] {
        KIND_READ,
        KIND_ECHO,
        KIND_LINE,
        KIND_CANCEL
    } item_kind_t;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_THIRD
    } phase_t;

    // decoded item handed from the front end to the result emitter
    typedef struct packed {
        item_kind_t  kind;
        logic [7:0]  data;
        logic [7:0]  length;
        logic        rd_hit;
    } sle_item_t;

endpackage

>>> hdl/serial_line_editor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_line_editor: line editing for received serial bytes
// edits one line held in a ram, gives echo bytes, line events and read replies
// ----------------------------------------------------------------------------
// path: the first result of an item is registered in the held item register and
//   then in the output register; a stalled output can hold it between them
// throughput: one item per cycle for items with one or no result while the output
//   does not stall; control-c holds the emitter until its third result is loaded
// reset: write index, escape count and high-water mark clear, limit is 256;
//   the line ram is not swept, entries at or above the high-water mark read as zero
module serial_line_editor
    import sle_pkg::*;
#(
    parameter int LINE_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel, line_limit
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // rx_byte, read_index
    input  logic        s_tuser,   // cmd
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // data_byte, line_length
    output logic [2:0]  m_tuser,   // is_echo, line_event
    output logic        m_tlast
);

    // only the first 256 entries are reachable through an 8 bit index
    localparam int STORE_DEPTH = (LINE_DEPTH < 256) ? LINE_DEPTH : 256;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CAP_INT     = (LINE_DEPTH - 1 < 255) ? LINE_DEPTH - 1 : 255;
    localparam logic [7:0] CAP_CHARS = 8'(CAP_INT);

    logic [8:0] limit_reg;
    logic [7:0] wi_reg;
    logic [7:0] wi_next;
    logic [7:0] hwm_reg;      // entries at or above this were never written
    logic [7:0] hwm_next;
    logic [2:0] esc_reg;
    logic [2:0] esc_next;

    logic              accept;
    logic [7:0]        rx_byte;
    logic [7:0]        read_index;
    logic              emit;
    sle_item_t         item;
    logic              item_ready;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [7:0]        ram_rdata;
    logic [7:0]        bs_pos;
    logic              room;

    assign cfg_ready  = 1'b1;
    assign s_tready   = item_ready;
    assign accept     = s_tvalid && s_tready;
    assign rx_byte    = s_tdata[7:0];
    assign read_index = s_tdata[15:8];
    assign bs_pos     = wi_reg - 8'd1;

    // room for one more character under both the limit and the store size
    assign room = (({1'b0, wi_reg} + 9'd1) < limit_reg) && (wi_reg < CAP_CHARS);

    // decode the accepted transaction, update line state and the ram
    always_comb
    begin
        wi_next     = wi_reg;
        hwm_next    = hwm_reg;
        esc_next    = esc_reg;
        emit        = 1'b0;
        item.kind   = KIND_ECHO;
        item.data   = rx_byte;
        item.length = 8'd0;
        item.rd_hit = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = wi_reg[ADDR_W-1:0];
        ram_wdata   = rx_byte;
        ram_re      = 1'b0;
        if (accept)
        begin
            if (s_tuser)
            begin
                // read reply, unwritten or out of range entries answer zero
                emit        = 1'b1;
                item.kind   = KIND_READ;
                item.rd_hit = read_index < hwm_reg;
                ram_re      = 1'b1;
            end
            else if (esc_reg != 3'd0)
            begin
                esc_next = esc_reg - 3'd1;
            end
            else
            begin
                case (rx_byte)
                    ASCII_ESC:
                    begin
                        esc_next = ESC_SKIP_COUNT;
                    end
                    ASCII_ETX:
                    begin
                        emit      = 1'b1;
                        item.kind = KIND_CANCEL;
                        wi_next   = 8'd0;
                    end
                    ASCII_CR, ASCII_LF:
                    begin
                        emit        = 1'b1;
                        item.kind   = KIND_LINE;
                        item.length = wi_reg;
                        wi_next     = 8'd0;
                    end
                    ASCII_BS, ASCII_DEL:
                    begin
                        // empty line: nothing happens
                        if (wi_reg != 8'd0)
                        begin
                            emit      = 1'b1;
                            item.data = ASCII_BS;
                            wi_next   = bs_pos;
                            ram_we    = 1'b1;
                            ram_waddr = bs_pos[ADDR_W-1:0];
                            ram_wdata = 8'd0;
                        end
                    end
                    default:
                    begin
                        if ((rx_byte inside {[PRINT_LO:PRINT_HI]}) && room)
                        begin
                            emit    = 1'b1;
                            wi_next = wi_reg + 8'd1;
                            ram_we  = 1'b1;
                            if (wi_reg == hwm_reg)
                            begin
                                hwm_next = hwm_reg + 8'd1;
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wi_reg  <= 8'd0;
            hwm_reg <= 8'd0;
            esc_reg <= 3'd0;
        end
        else
        begin
            wi_reg  <= wi_next;
            hwm_reg <= hwm_next;
            esc_reg <= esc_next;
        end
    end

    // line limit register; the user must write it only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 9'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    // line store; the read data holds until the next read transaction
    sle_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (read_index[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // decoded item waits here and leaves as one to three results
    sle_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (accept && emit),
        .item       (item),
        .item_ready (item_ready),
        .rd_data    (ram_rdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // the line never runs past the entries that were written
    a_wi_below_hwm: assert property (@(posedge clk) disable iff (!rst_n)
        wi_reg <= hwm_reg)
        else $error("write index above high-water mark");

    // written entries stay inside the usable store
    a_hwm_cap: assert property (@(posedge clk) disable iff (!rst_n)
        hwm_reg <= CAP_CHARS)
        else $error("high-water mark beyond capacity");

    // escape count never reloads above its start value
    a_esc_range: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg <= ESC_SKIP_COUNT)
        else $error("escape count out of range");

endmodule

>>> hdl/sle_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_ram: generic simple dual port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module sle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/sle_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_emit: result emitter
// holds one decoded item and turns it into one to three output results
// ----------------------------------------------------------------------------
module sle_emit
    import sle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  sle_item_t   item,
    output logic        item_ready,
    input  logic [7:0]  rd_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // data_byte, line_length
    output logic [2:0]  m_tuser,   // is_echo, line_event
    output logic        m_tlast
);

    logic       held_valid_reg;
    sle_item_t  held_reg;
    phase_t     phase_reg;
    phase_t     phase_next;

    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic       out_echo_reg;
    logic [1:0] out_event_reg;
    logic [7:0] out_len_reg;
    logic       out_last_reg;

    logic       res_load;
    logic [7:0] res_data;
    logic       res_echo;
    logic [1:0] res_event;
    logic [7:0] res_len;
    logic       res_last;
    logic       held_done;

    assign res_load   = held_valid_reg && (!out_valid_reg || m_tready);
    assign held_done  = res_load && res_last;
    assign item_ready = !held_valid_reg || held_done;

    // result for the current phase of the held item
    always_comb
    begin
        res_data  = held_reg.data;
        res_echo  = 1'b1;
        res_event = EV_NONE;
        res_len   = 8'd0;
        res_last  = 1'b1;
        case (held_reg.kind)
            KIND_READ:
            begin
                res_data = held_reg.rd_hit ? rd_data : 8'd0;
                res_echo = 1'b0;
            end
            KIND_ECHO:
            begin
                res_data = held_reg.data;
            end
            KIND_LINE:
            begin
                res_data  = ASCII_LF;
                res_event = EV_LINE;
                res_len   = held_reg.length;
            end
            KIND_CANCEL:
            begin
                case (phase_reg)
                    PH_FIRST:
                    begin
                        res_data = ASCII_CARET;
                        res_last = 1'b0;
                    end
                    PH_SECOND:
                    begin
                        res_data = ASCII_C;
                        res_last = 1'b0;
                    end
                    default:
                    begin
                        res_data  = ASCII_LF;
                        res_event = EV_CANCEL;
                    end
                endcase
            end
            default:
            begin
                res_data = held_reg.data;
            end
        endcase
    end

    // phase sequencing
    always_comb
    begin
        phase_next = phase_reg;
        if (item_valid && item_ready)
        begin
            phase_next = PH_FIRST;
        end
        else if (res_load && !res_last)
        begin
            case (phase_reg)
                PH_FIRST:  phase_next = PH_SECOND;
                PH_SECOND: phase_next = PH_THIRD;
                default:   phase_next = PH_THIRD;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
        end
        else if (item_valid && item_ready)
        begin
            held_valid_reg <= 1'b1;
        end
        else if (held_done)
        begin
            held_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            held_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_data_reg  <= res_data;
            out_echo_reg  <= res_echo;
            out_event_reg <= res_event;
            out_len_reg   <= res_len;
            out_last_reg  <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_len_reg, out_data_reg};
    assign m_tuser  = {out_event_reg, out_echo_reg};
    assign m_tlast  = out_last_reg;

    // a line event always closes the results of its item
    a_event_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[2:1] != EV_NONE)) |-> m_tlast)
        else $error("line event on a result that is not last");

    // only a cancel walks past its first phase
    a_phase_cancel: assert property (@(posedge clk) disable iff (!rst_n)
        (held_valid_reg && (phase_reg != PH_FIRST)) |-> (held_reg.kind == KIND_CANCEL))
        else $error("phase advanced on a single result item");

endmodule

>>> verif/serial_line_editor_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_line_editor_test: self-checking bench for the serial line editor
// drives received bytes and read commands with random gaps and output stalls,
// tracks the line store, the escape skip and the line limit on its own side
// and compares every result transaction field by field in arrival order
// ----------------------------------------------------------------------------
module serial_line_editor_test;
    import sle_pkg::*;

    // input item kinds carried on s_tuser
    localparam bit CMD_RX   = 1'b0;
    localparam bit CMD_READ = 1'b1;

    localparam logic [7:0] ASCII_TAB = 8'h09;

    // generous bound on the whole run, far above the slowest legal run
    localparam int CYCLE_LIMIT = 400000;
    // cycles allowed after the last result for items that give none
    localparam int DRAIN_CYCLES = 8;

    // one result transaction as the block should present it
    typedef struct packed {
        logic [7:0] data;
        logic       is_echo;
        logic [1:0] ev;
        logic [7:0] len;
        logic       fin;
    } echo_reply_t;

    // ------------------------------------------------------------------------
    // line state tracker: follows the editor's line store, fill count, escape
    // skip and limit, and keeps the queue of replies still owed by the block
    // ------------------------------------------------------------------------
    class line_edit_tracker;
        logic [7:0]  chars [256];
        logic [7:0]  fill;
        logic [2:0]  skip;
        logic [8:0]  limit;
        echo_reply_t owed [$];
        int          errors;

        function new();
            foreach (chars[i])
                chars[i] = 8'd0;
            fill   = 8'd0;
            skip   = 3'd0;
            limit  = 9'd256;
            errors = 0;
        endfunction

        function void set_limit(logic [8:0] v);
            limit = v;
        endfunction

        function void owe(logic [7:0] d, logic e, logic [1:0] ev, logic [7:0] n,
                          logic f);
            echo_reply_t r;
            r.data    = d;
            r.is_echo = e;
            r.ev      = ev;
            r.len     = n;
            r.fin     = f;
            owed.push_back(r);
        endfunction

        // note one accepted input transaction and owe its replies
        function void take_item(bit cmd, logic [7:0] rx, logic [7:0] ri);
            if (cmd == CMD_READ)
            begin
                owe(chars[ri], 1'b0, EV_NONE, 8'd0, 1'b1);
                return;
            end
            if (skip != 3'd0)
            begin
                skip = skip - 3'd1;
                return;
            end
            if (rx == ASCII_ESC)
            begin
                skip = ESC_SKIP_COUNT;
            end
            else if (rx == ASCII_ETX)
            begin
                owe(ASCII_CARET, 1'b1, EV_NONE, 8'd0, 1'b0);
                owe(ASCII_C, 1'b1, EV_NONE, 8'd0, 1'b0);
                owe(ASCII_LF, 1'b1, EV_CANCEL, 8'd0, 1'b1);
                fill = 8'd0;
            end
            else if (rx == ASCII_CR || rx == ASCII_LF)
            begin
                owe(ASCII_LF, 1'b1, EV_LINE, fill, 1'b1);
                fill = 8'd0;
            end
            else if (rx == ASCII_BS || rx == ASCII_DEL)
            begin
                if (fill != 8'd0)
                begin
                    fill = fill - 8'd1;
                    chars[fill] = 8'd0;
                    owe(ASCII_BS, 1'b1, EV_NONE, 8'd0, 1'b1);
                end
            end
            else if (rx >= PRINT_LO && rx <= PRINT_HI)
            begin
                // room only while the line stays below limit-1 and 255
                if ((int'(fill) + 1 < int'(limit)) && (fill < 8'd255))
                begin
                    chars[fill] = rx;
                    fill = fill + 8'd1;
                    owe(rx, 1'b1, EV_NONE, 8'd0, 1'b1);
                end
            end
        endfunction

        // compare one accepted result transaction with the oldest reply owed
        function void match_result(logic [7:0] d, logic e, logic [1:0] ev,
                                   logic [7:0] n, logic f);
            echo_reply_t r;
            if (owed.size() == 0)
            begin
                $error("unexpected result: data_byte %0h is_echo %0b", d, e);
                errors++;
                return;
            end
            r = owed.pop_front();
            if (d !== r.data)
            begin
                $error("data_byte: expected %0h, got %0h", r.data, d);
                errors++;
            end
            if (e !== r.is_echo)
            begin
                $error("is_echo: expected %0b, got %0b", r.is_echo, e);
                errors++;
            end
            if (ev !== r.ev)
            begin
                $error("line_event: expected %0d, got %0d", r.ev, ev);
                errors++;
            end
            if (n !== r.len)
            begin
                $error("line_length: expected %0d, got %0d", r.len, n);
                errors++;
            end
            if (f !== r.fin)
            begin
                $error("last: expected %0b, got %0b", r.fin, f);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block ports, the driven ones at known values from time zero
    // ------------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [8:0]  cfg_data  = 9'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = 16'd0;   // rx_byte, read_index
    logic        s_tuser   = 1'b0;    // cmd
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;             // data_byte, line_length
    logic [2:0]  m_tuser;             // is_echo, line_event
    logic        m_tlast;

    line_edit_tracker trk = new();

    // no idling on either side while this is set
    bit steady = 1'b0;
    int sent   = 0;
    int cycles = 0;

    serial_line_editor u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // run-length guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side stalls in about 14 percent of cycles while steady is clear
    always @(posedge clk)
    begin
        m_tready <= steady || ($urandom_range(99) >= 14);
    end

    // every result transaction goes to the tracker in arrival order
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            trk.match_result(m_tdata[7:0], m_tuser[0], m_tuser[2:1], m_tdata[15:8],
                             m_tlast);
    end

    // ------------------------------------------------------------------------
    // stimulus tasks
    // ------------------------------------------------------------------------

    // one input transaction, with an occasional idle gap ahead of it
    task automatic send_item(bit cmd, logic [7:0] rx, logic [7:0] ri);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(99) < 16)
            gap = 1;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ri, rx};
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        trk.take_item(cmd, rx, ri);
        sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(CMD_RX, b, 8'($urandom_range(255)));
    endtask

    task automatic send_read(logic [7:0] idx);
        send_item(CMD_READ, 8'($urandom_range(255)), idx);
    endtask

    // stop input and let every owed reply and any silent item finish
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (trk.owed.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // line_limit write, only from an idle block
    task automatic write_limit(logic [8:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        trk.set_limit(v);
    endtask

    // one typed line: printable text with some rubouts, then an ending
    task automatic type_line();
        int n;
        int pick;
        n = ($urandom_range(7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 15)
                send_byte($urandom_range(1) ? ASCII_BS : ASCII_DEL);
            else
                send_byte(8'($urandom_range(32, 126)));
        end
        pick = $urandom_range(9);
        if (pick == 0)
            send_byte(ASCII_ETX);
        else if (pick < 5)
            send_byte(ASCII_CR);
        else
            send_byte(ASCII_LF);
        // fetch part of the finished line back, a little past its end too
        if ($urandom_range(99) < 40)
            repeat ($urandom_range(1, 3)) send_read(8'($urandom_range(0, n + 2)));
    endtask

    // mostly well-formed lines, plus escapes, cancels, reads and raw noise
    task automatic random_traffic(int count);
        int goal;
        int pick;
        goal = sent + count;
        while (sent < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                type_line();
            else if (pick < 65)
            begin
                // escape followed by four swallowed bytes of any value
                send_byte(ASCII_ESC);
                repeat (4) send_byte(8'($urandom_range(255)));
            end
            else if (pick < 72)
                send_byte(ASCII_ETX);
            else if (pick < 84)
                send_read(8'($urandom_range(255)));
            else
                send_byte(8'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [8:0] limits [3];
        limits = '{9'd3, 9'd9, 9'd40};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset limit of 256
        send_read(8'd0);            // untouched store reads zero
        send_read(8'd255);
        send_byte(ASCII_BS);        // rubout on an empty line is silent
        send_byte(ASCII_DEL);
        send_byte(PRINT_LO);
        send_byte(PRINT_HI);
        send_byte(8'h41);
        send_byte(ASCII_DEL);       // removes the last character
        send_byte(8'h1F);           // control, ignored
        send_byte(8'h80);           // above printable, ignored
        send_byte(8'hFF);
        send_byte(ASCII_TAB);
        send_byte(ASCII_ESC);       // escape, then four dropped bytes
        send_byte(ASCII_ESC);
        send_byte(8'h78);
        send_byte(8'h79);
        send_byte(ASCII_ETX);
        send_byte(8'h7A);
        send_byte(ASCII_CR);        // line of three
        send_read(8'd2);
        send_read(8'd3);            // never written, reads zero
        send_byte(ASCII_LF);        // empty line
        send_byte(8'h71);
        send_byte(ASCII_ETX);       // cancel
        send_read(8'd0);            // past line end keeps the old character

        // smallest limit that still takes a character: one character per line
        write_limit(9'd2);
        send_byte(8'h61);
        send_byte(8'h62);           // full line, silent
        send_byte(ASCII_CR);
        send_read(8'd1);

        // limit of 256: fill the line to its 255 characters, overflow, rub out one,
        // all of it with no idling on either side
        write_limit(9'd256);
        steady = 1'b1;
        repeat (257) send_byte(8'($urandom_range(32, 126)));
        send_byte(ASCII_DEL);
        send_byte(ASCII_CR);
        send_read(8'd254);
        send_read(8'd253);
        steady = 1'b0;

        // random phases over several limits
        foreach (limits[i])
        begin
            write_limit(limits[i]);
            random_traffic(6);
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (trk.errors == 0 && trk.owed.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
